FILE: hw/rtl/seg_tri_pkg.sv
// ----------------------------------------------------------------------------
// Segment/triangle intersection package
// Shared widths, register codes and the divider stage type for the core.
// ----------------------------------------------------------------------------
`default_nettype none

package seg_tri_pkg;

  localparam int COORD_W = 20;
  localparam int NORM_W  = 16;
  localparam int VERT_W  = 3 * COORD_W;
  localparam int NVEC_W  = 3 * NORM_W;
  localparam int LTOL_W  = 16;
  localparam int ETOL_W  = 32;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;

  // Numerator and denominator of the segment parameter, and their magnitudes.
  localparam int DEN_W = 39;
  // Quotient bits kept; a larger quotient is rejected up front, before the divider.
  localparam int QW    = 19;
  localparam int PIPE_DIV = QW;

  localparam int LAM_ONE = 65536;
  localparam int CROSS_W = 38;
  localparam int EPROD_W = 59;
  localparam int ESUM_W  = 61;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sd524287;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -20'sd524288;

  // Register indexes, address bits [5:3].
  localparam logic [2:0] REG_VERT_A  = 3'd0;
  localparam logic [2:0] REG_VERT_B  = 3'd1;
  localparam logic [2:0] REG_VERT_C  = 3'd2;
  localparam logic [2:0] REG_NORMAL  = 3'd3;
  localparam logic [2:0] REG_OFFSET  = 3'd4;
  localparam logic [2:0] REG_LAM_TOL = 3'd5;
  localparam logic [2:0] REG_EDG_TOL = 3'd6;

  localparam logic [LTOL_W-1:0] LAM_TOL_RST = 16'd7;
  localparam logic [ETOL_W-1:0] EDG_TOL_RST = 32'd107374;

  typedef struct packed {
    logic [DEN_W-1:0]            rem;
    logic [DEN_W-1:0]            den;
    logic [2:0]                  nlo;
    logic [QW-1:0]               q;
    logic                        neg;
    logic                        rej;
    logic [5:0][COORD_W-1:0]     pts;
  } div_stage_t;

endpackage

`default_nettype wire

FILE: hw/rtl/segment_triangle_intersect_core.sv
// ----------------------------------------------------------------------------
// Segment/triangle intersection core
// Fully pipelined fixed-point test of one segment against a configured
// triangle and its plane, returning a hit flag and the intersection point.
// ----------------------------------------------------------------------------
//
// Usage. A request carries the segment end points (in_start_*, in_end_*) and
// is taken at a rising edge where start is high and busy is low. busy is held
// low: the pipeline never stalls, so a new request may enter every cycle and
// the sustained rate is one request per clock.
// Each request produces exactly one result, presented on out_is_hit and
// out_hit_* for a single cycle with out_strobe high. The strobe rises once
// the request has passed stages 1 and 2, the divider and the lambda,
// weighting, rounding, edge product and edge sum stages. The receiver cannot
// hold results off, so nothing is buffered at the output; results leave in
// request order. The segment parameter comes from a restoring divider with
// one quotient bit per pipeline stage (19 stages), followed by the hit-point
// and edge-test arithmetic. The user must write the triangle, plane and
// tolerances over the APB port only while no request is in flight; the block
// itself does not enforce this. Precomputed edge cross products settle after
// a write. A synchronous reset (rst_n low) clears all valid bits and sets
// the configuration registers to reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_triangle_intersect_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Request channel
  input  wire                                  start,
  output logic                                 busy,
  input  wire  signed [seg_tri_pkg::COORD_W-1:0] in_start_x,
  input  wire  signed [seg_tri_pkg::COORD_W-1:0] in_start_y,
  input  wire  signed [seg_tri_pkg::COORD_W-1:0] in_start_z,
  input  wire  signed [seg_tri_pkg::COORD_W-1:0] in_end_x,
  input  wire  signed [seg_tri_pkg::COORD_W-1:0] in_end_y,
  input  wire  signed [seg_tri_pkg::COORD_W-1:0] in_end_z,
  // Result channel
  output logic                                 out_strobe,
  output logic                                 out_is_hit,
  output logic signed [seg_tri_pkg::COORD_W-1:0] out_hit_x,
  output logic signed [seg_tri_pkg::COORD_W-1:0] out_hit_y,
  output logic signed [seg_tri_pkg::COORD_W-1:0] out_hit_z,
  // Configuration port
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [seg_tri_pkg::ADDR_W-1:0]       paddr,
  input  wire  [seg_tri_pkg::DATA_W-1:0]       pwdata,
  output logic [seg_tri_pkg::DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import seg_tri_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [VERT_W-1:0]  cfg_vert_r [3];
  logic [NVEC_W-1:0]  cfg_normal_r;
  logic [COORD_W-1:0] cfg_offset_r;
  logic [LTOL_W-1:0]  cfg_lam_tol_r;
  logic [ETOL_W-1:0]  cfg_edg_tol_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        cfg_vert_r[k] <= '0;
      end
      cfg_normal_r  <= '0;
      cfg_offset_r  <= '0;
      cfg_lam_tol_r <= LAM_TOL_RST;
      cfg_edg_tol_r <= EDG_TOL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_VERT_A:  cfg_vert_r[0] <= pwdata[VERT_W-1:0];
        REG_VERT_B:  cfg_vert_r[1] <= pwdata[VERT_W-1:0];
        REG_VERT_C:  cfg_vert_r[2] <= pwdata[VERT_W-1:0];
        REG_NORMAL:  cfg_normal_r  <= pwdata[NVEC_W-1:0];
        REG_OFFSET:  cfg_offset_r  <= pwdata[COORD_W-1:0];
        REG_LAM_TOL: cfg_lam_tol_r <= pwdata[LTOL_W-1:0];
        REG_EDG_TOL: cfg_edg_tol_r <= pwdata[ETOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_VERT_A:  prdata = DATA_W'(cfg_vert_r[0]);
      REG_VERT_B:  prdata = DATA_W'(cfg_vert_r[1]);
      REG_VERT_C:  prdata = DATA_W'(cfg_vert_r[2]);
      REG_NORMAL:  prdata = DATA_W'(cfg_normal_r);
      REG_OFFSET:  prdata = DATA_W'(cfg_offset_r);
      REG_LAM_TOL: prdata = DATA_W'(cfg_lam_tol_r);
      REG_EDG_TOL: prdata = DATA_W'(cfg_edg_tol_r);
      default:     prdata = '0;
    endcase
  end

  // Unpacked views of the triangle and the normal.
  logic signed [COORD_W-1:0] vtx [3][3];
  logic signed [NORM_W-1:0]  nrm [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        vtx[k][c] = $signed(cfg_vert_r[k][COORD_W*c +: COORD_W]);
      end
      nrm[k] = $signed(cfg_normal_r[NORM_W*k +: NORM_W]);
    end
  end

  // --------------------------------------------------------------------------
  // Edge cross products (V_next - V) x n, recomputed from the registers in
  // two stages. They only change after a configuration write.
  // --------------------------------------------------------------------------
  logic signed [CROSS_W-2:0] xp_r [3][6];
  logic signed [CROSS_W-1:0] cr_r [3][3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      logic signed [COORD_W:0] e0, e1, e2;
      e0 = 21'(vtx[(j+1)%3][0]) - 21'(vtx[j][0]);
      e1 = 21'(vtx[(j+1)%3][1]) - 21'(vtx[j][1]);
      e2 = 21'(vtx[(j+1)%3][2]) - 21'(vtx[j][2]);
      xp_r[j][0] <= e1 * nrm[2];
      xp_r[j][1] <= e2 * nrm[1];
      xp_r[j][2] <= e2 * nrm[0];
      xp_r[j][3] <= e0 * nrm[2];
      xp_r[j][4] <= e0 * nrm[1];
      xp_r[j][5] <= e1 * nrm[0];
      cr_r[j][0] <= CROSS_W'(xp_r[j][0]) - CROSS_W'(xp_r[j][1]);
      cr_r[j][1] <= CROSS_W'(xp_r[j][2]) - CROSS_W'(xp_r[j][3]);
      cr_r[j][2] <= CROSS_W'(xp_r[j][4]) - CROSS_W'(xp_r[j][5]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: normal products n.c * p.c for both end points.
  // --------------------------------------------------------------------------
  logic                      s1_vld_r;
  logic signed [COORD_W-1:0] s1_pt_r [6];
  logic signed [35:0]        s1_m_r  [6];
  logic signed [COORD_W-1:0] in_pt   [6];

  assign in_pt[0] = in_start_x;
  assign in_pt[1] = in_start_y;
  assign in_pt[2] = in_start_z;
  assign in_pt[3] = in_end_x;
  assign in_pt[4] = in_end_y;
  assign in_pt[5] = in_end_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      s1_pt_r[i] <= in_pt[i];
      s1_m_r[i]  <= in_pt[i] * nrm[i % 3];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: numerator d + n.p1 and denominator n.p1 - n.p0, scale 2^-22.
  // --------------------------------------------------------------------------
  logic                      s2_vld_r;
  logic [5:0][COORD_W-1:0]   s2_pts_r;
  logic signed [DEN_W-1:0]   s2_num_r;
  logic signed [DEN_W-1:0]   s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [DEN_W-1:0] np0, np1;
    np0 = DEN_W'(s1_m_r[0]) + DEN_W'(s1_m_r[1]) + DEN_W'(s1_m_r[2]);
    np1 = DEN_W'(s1_m_r[3]) + DEN_W'(s1_m_r[4]) + DEN_W'(s1_m_r[5]);
    s2_num_r <= (DEN_W'($signed(cfg_offset_r)) <<< 14) + np1;
    s2_den_r <= np1 - np0;
    for (int i = 0; i < 6; i++) begin
      s2_pts_r[i] <= s1_pt_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 and divider: |num| * 2^16 / |den| by restoring division, one
  // quotient bit per stage. A quotient of 2^19 or more is rejected up front,
  // which leaves the remainder of the top part below the divisor.
  // --------------------------------------------------------------------------
  logic       dv_vld_r [PIPE_DIV+1];
  div_stage_t dv_r     [PIPE_DIV+1];
  div_stage_t dv_nxt   [PIPE_DIV+1];

  always_comb begin
    logic [DEN_W-1:0] absn, absd;
    absn = s2_num_r[DEN_W-1] ? DEN_W'(-s2_num_r) : DEN_W'(s2_num_r);
    absd = s2_den_r[DEN_W-1] ? DEN_W'(-s2_den_r) : DEN_W'(s2_den_r);
    dv_nxt[0].rem = DEN_W'(absn >> 3);
    dv_nxt[0].den = absd;
    dv_nxt[0].nlo = absn[2:0];
    dv_nxt[0].q   = '0;
    dv_nxt[0].neg = s2_num_r[DEN_W-1] ^ s2_den_r[DEN_W-1];
    dv_nxt[0].rej = (absd == '0) || ({3'b000, absn} >= {absd, 3'b000});
    dv_nxt[0].pts = s2_pts_r;
    for (int k = 0; k < PIPE_DIV; k++) begin
      logic             nb;
      logic [DEN_W:0]   trial;
      dv_nxt[k+1] = dv_r[k];
      nb = ((QW - 1 - k) >= 16) ? dv_r[k].nlo[2'(QW - 1 - k - 16)] : 1'b0;
      trial = {dv_r[k].rem, nb};
      if (trial >= {1'b0, dv_r[k].den}) begin
        dv_nxt[k+1].rem              = DEN_W'(trial - {1'b0, dv_r[k].den});
        dv_nxt[k+1].q[QW - 1 - k]    = 1'b1;
      end else begin
        dv_nxt[k+1].rem              = DEN_W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= PIPE_DIV; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
    end else begin
      dv_vld_r[0] <= s2_vld_r;
      for (int k = 0; k < PIPE_DIV; k++) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= PIPE_DIV; k++) begin
      dv_r[k] <= dv_nxt[k];
    end
  end

  // --------------------------------------------------------------------------
  // Lambda stage: signed Q3.16 lambda and the range test.
  // --------------------------------------------------------------------------
  div_stage_t                dq;
  logic                      lm_vld_r;
  logic                      lm_acc_r;
  logic signed [COORD_W-1:0] lm_lam_r;
  logic [5:0][COORD_W-1:0]   lm_pts_r;

  assign dq = dv_r[PIPE_DIV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lm_vld_r <= 1'b0;
    end else begin
      lm_vld_r <= dv_vld_r[PIPE_DIV];
    end
  end

  always_ff @(posedge clk) begin
    logic in_rng;
    if (dq.neg) begin
      in_rng = dq.q <= QW'(cfg_lam_tol_r);
    end else begin
      in_rng = COORD_W'(dq.q) <= COORD_W'(LAM_ONE) + COORD_W'(cfg_lam_tol_r);
    end
    lm_acc_r <= !dq.rej && in_rng;
    lm_lam_r <= dq.neg ? -$signed({1'b0, dq.q}) : $signed({1'b0, dq.q});
    lm_pts_r <= dq.pts;
  end

  // --------------------------------------------------------------------------
  // Weighting stage: p0 * lambda and p1 * (1 - lambda) per coordinate.
  // --------------------------------------------------------------------------
  logic               wt_vld_r;
  logic               wt_acc_r;
  logic signed [40:0] wt_a_r [3];
  logic signed [40:0] wt_b_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_vld_r <= 1'b0;
    end else begin
      wt_vld_r <= lm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [COORD_W:0] omlam;
    omlam = 21'sd65536 - 21'(lm_lam_r);
    wt_acc_r <= lm_acc_r;
    for (int c = 0; c < 3; c++) begin
      wt_a_r[c] <= $signed(lm_pts_r[c]) * lm_lam_r;
      wt_b_r[c] <= $signed(lm_pts_r[c + 3]) * omlam;
    end
  end

  // --------------------------------------------------------------------------
  // Rounding stage: round half up to Q11.8 and saturate. Rejected segments
  // leave a zero point.
  // --------------------------------------------------------------------------
  logic                      rd_vld_r;
  logic                      rd_acc_r;
  logic signed [COORD_W-1:0] rd_h_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= wt_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic signed [41:0] t;
      logic signed [25:0] sh;
      t  = 42'(wt_a_r[c]) + 42'(wt_b_r[c]) + 42'sd32768;
      sh = t[41:16];
      if (!wt_acc_r) begin
        rd_h_r[c] <= '0;
      end else if (sh > 26'(COORD_MAX)) begin
        rd_h_r[c] <= COORD_MAX;
      end else if (sh < 26'(COORD_MIN)) begin
        rd_h_r[c] <= COORD_MIN;
      end else begin
        rd_h_r[c] <= sh[COORD_W-1:0];
      end
    end
    rd_acc_r <= wt_acc_r;
  end

  // --------------------------------------------------------------------------
  // Edge product stage: cross(edge) . (hit - V) terms, one per coordinate.
  // --------------------------------------------------------------------------
  logic                      ep_vld_r;
  logic                      ep_acc_r;
  logic signed [COORD_W-1:0] ep_h_r [3];
  logic signed [EPROD_W-1:0] ep_p_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_vld_r <= 1'b0;
    end else begin
      ep_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [COORD_W:0] qv;
        qv = 21'(rd_h_r[c]) - 21'(vtx[j][c]);
        ep_p_r[j][c] <= cr_r[j][c] * qv;
      end
      ep_h_r[j] <= rd_h_r[j];
    end
    ep_acc_r <= rd_acc_r;
  end

  // --------------------------------------------------------------------------
  // Edge sum stage.
  // --------------------------------------------------------------------------
  logic                      es_vld_r;
  logic                      es_acc_r;
  logic signed [COORD_W-1:0] es_h_r [3];
  logic signed [ESUM_W-1:0]  es_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      es_vld_r <= 1'b0;
    end else begin
      es_vld_r <= ep_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      es_d_r[j] <= ESUM_W'(ep_p_r[j][0]) + ESUM_W'(ep_p_r[j][1]) + ESUM_W'(ep_p_r[j][2]);
      es_h_r[j] <= ep_h_r[j];
    end
    es_acc_r <= ep_acc_r;
  end

  // --------------------------------------------------------------------------
  // Output stage: side tests against the edge tolerance, either winding.
  // --------------------------------------------------------------------------
  logic signed [ESUM_W-1:0] etol;
  logic                     all_lo;
  logic                     all_hi;

  assign etol   = $signed({{(ESUM_W - ETOL_W){1'b0}}, cfg_edg_tol_r});
  assign all_lo = (es_d_r[0] < etol) && (es_d_r[1] < etol) && (es_d_r[2] < etol);
  assign all_hi = (es_d_r[0] > -etol) && (es_d_r[1] > -etol) && (es_d_r[2] > -etol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= es_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_is_hit <= es_acc_r && (all_lo || all_hi);
    out_hit_x  <= es_h_r[0];
    out_hit_y  <= es_h_r[1];
    out_hit_z  <= es_h_r[2];
  end

endmodule

`default_nettype wire
